// ----- hw/rtl/sibe_pkg.sv -----
package sibe_pkg;

   // Sizes of the request fields and configuration registers
   localparam int STACK_BYTES_DEF = 4096;
   localparam int ADDR_W          = 32;
   localparam int SPAN_W          = 12;
   localparam int LEN_W           = 13;
   // Bit position inside a run; offset (span) plus length can overflow it
   localparam int POS_W           = 13;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 32;

   localparam logic [7:0]        BYTE_ONES      = 8'hFF;
   localparam logic [SPAN_W-1:0] SPAN_RESET     = 12'd4095;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_SPAN = 2'd1;

   // Request operations
   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_MARK   = 2'd1,
      OP_UNMARK = 2'd2,
      OP_COPY   = 2'd3
   } op_type;

   // Datapath actions, one per control word
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CLR_STORE,
      ACT_TAKE,
      ACT_OFFSETS,
      ACT_BOUNDS,
      ACT_RD_DST,
      ACT_BYTE_OP,
      ACT_RESPOND,
      ACT_RD_SRC,
      ACT_GRAB,
      ACT_PUT
   } act_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_CLR_LAST,
      COND_REQ_FIRE,
      COND_EMPTY,
      COND_COPY_BITS,
      COND_BYTE_LAST,
      COND_BIT_LAST,
      COND_RSP_FREE
   } cond_type;

   // Microprogram step addresses
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFFS,
      ST_BOUNDS,
      ST_DISP,
      ST_ROUTE,
      ST_RD_DST,
      ST_BYTE,
      ST_RESP,
      ST_RD_SRC,
      ST_GRAB,
      ST_PUT,
      ST_TO_RESP
   } step_type;

   // One control word: action, jump condition, jump target.
   // Condition xor invert false: stay if hold is set, else fall through.
   typedef struct packed {
      act_type  act;
      cond_type cond;
      logic     invert;
      logic     hold;
      step_type target;
   } ucode_type;

   // Datapath status fed back to the sequencer
   typedef struct packed {
      logic clr_last;
      logic req_fire;
      logic empty;
      logic copy_bits;
      logic byte_last;
      logic bit_last;
      logic rsp_free;
   } status_type;

   function automatic ucode_type uword(act_type a, cond_type c, logic inv, logic hld,
                                       step_type t);
      ucode_type w;
      w.act    = a;
      w.cond   = c;
      w.invert = inv;
      w.hold   = hld;
      w.target = t;
      return w;
   endfunction

   // Microprogram ROM
   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      unique case (s)
         // sweep the store to zero after reset
         ST_CLEAR:   w = uword(ACT_CLR_STORE, COND_CLR_LAST,  1'b0, 1'b1, ST_IDLE);
         ST_IDLE:    w = uword(ACT_TAKE,      COND_REQ_FIRE,  1'b0, 1'b1, ST_OFFS);
         ST_OFFS:    w = uword(ACT_OFFSETS,   COND_ALWAYS,    1'b0, 1'b0, ST_BOUNDS);
         ST_BOUNDS:  w = uword(ACT_BOUNDS,    COND_ALWAYS,    1'b0, 1'b0, ST_DISP);
         ST_DISP:    w = uword(ACT_NONE,      COND_EMPTY,     1'b0, 1'b0, ST_RESP);
         ST_ROUTE:   w = uword(ACT_NONE,      COND_COPY_BITS, 1'b0, 1'b0, ST_RD_SRC);
         // byte loop: check, mark, unmark, copy from outside
         ST_RD_DST:  w = uword(ACT_RD_DST,    COND_ALWAYS,    1'b0, 1'b0, ST_BYTE);
         ST_BYTE:    w = uword(ACT_BYTE_OP,   COND_BYTE_LAST, 1'b1, 1'b0, ST_RD_DST);
         ST_RESP:    w = uword(ACT_RESPOND,   COND_RSP_FREE,  1'b0, 1'b1, ST_IDLE);
         // bit loop: copy
         ST_RD_SRC:  w = uword(ACT_RD_SRC,    COND_ALWAYS,    1'b0, 1'b0, ST_GRAB);
         ST_GRAB:    w = uword(ACT_GRAB,      COND_ALWAYS,    1'b0, 1'b0, ST_PUT);
         ST_PUT:     w = uword(ACT_PUT,       COND_BIT_LAST,  1'b1, 1'b0, ST_RD_SRC);
         ST_TO_RESP: w = uword(ACT_NONE,      COND_ALWAYS,    1'b0, 1'b0, ST_RESP);
         default:    w = uword(ACT_NONE,      COND_ALWAYS,    1'b0, 1'b0, ST_CLEAR);
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/shadow_init_bitmap_engine.sv -----
// Shadow initialization bitmap: one "defined" bit per byte of a stack region.
// Request channel (req_*): op, address, source_address, length; an item is
// taken when req_valid is high and req_stall is low. Result channel (rsp_*):
// uninitialized and outside_region, one item per request, taken when
// rsp_valid is high and rsp_stall is low. Configuration (csr_*): stack_base
// at index 0, stack_span at index 1, always ready; write only while idle.
// Timing is set by a microcoded sequencer and the bitmap RAM, which has one
// write and one read port. An outside address or a run wholly past the store
// skips the bitmap; check / mark / unmark / copy from outside step through
// each bitmap byte touched (read, then check or update); copy steps through
// each bit copied (read source, read destination, write).
// The next item can be taken in the cycle after the result loads.
// One item is in work at a time. If the receiver stalls, the result stays
// in the output register; the next item is still taken and worked, then the
// sequencer waits in its respond step until that register frees.
// Reset (synchronous) clears base to 0 and span to 4095, then a sweep
// clears the bitmap one byte per cycle, (STACK_BYTES+7)/8 bytes in all,
// during which req_stall stays high.
module shadow_init_bitmap_engine #(
   parameter int STACK_BYTES = sibe_pkg::STACK_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [sibe_pkg::ADDR_W-1:0]       req_address,
   input  logic [sibe_pkg::ADDR_W-1:0]       req_source_address,
   input  logic [sibe_pkg::LEN_W-1:0]        req_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_uninitialized,
   output logic                              rsp_outside_region,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sibe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sibe_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [sibe_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [sibe_pkg::SPAN_W-1:0] span_ff, span_in;
   sibe_pkg::act_type           act;
   sibe_pkg::status_type        status;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      span_in = span_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sibe_pkg::CSR_STACK_BASE: base_in = csr_data;
            sibe_pkg::CSR_STACK_SPAN: span_in = csr_data[sibe_pkg::SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         span_ff <= sibe_pkg::SPAN_RESET;
      end else begin
         base_ff <= base_in;
         span_ff <= span_in;
      end
   end

   sibe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .act    (act)
   );

   sibe_dpath #(
      .STACK_BYTES (STACK_BYTES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .act                (act),
      .status             (status),
      .stack_base         (base_ff),
      .stack_span         (span_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_source_address (req_source_address),
      .req_length         (req_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_uninitialized  (rsp_uninitialized),
      .rsp_outside_region (rsp_outside_region)
   );

endmodule

// ----- hw/rtl/sibe_ram.sv -----
module sibe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sibe_seq.sv -----
module sibe_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  sibe_pkg::status_type status,
   output sibe_pkg::act_type    act
);

   sibe_pkg::step_type  upc_ff;
   sibe_pkg::step_type  upc_in;
   sibe_pkg::ucode_type word;
   logic                cond_met;
   logic                jump;

   assign word = sibe_pkg::ucode_rom(upc_ff);
   assign act  = word.act;

   // condition select
   always_comb begin
      unique case (word.cond)
         sibe_pkg::COND_ALWAYS:    cond_met = 1'b1;
         sibe_pkg::COND_CLR_LAST:  cond_met = status.clr_last;
         sibe_pkg::COND_REQ_FIRE:  cond_met = status.req_fire;
         sibe_pkg::COND_EMPTY:     cond_met = status.empty;
         sibe_pkg::COND_COPY_BITS: cond_met = status.copy_bits;
         sibe_pkg::COND_BYTE_LAST: cond_met = status.byte_last;
         sibe_pkg::COND_BIT_LAST:  cond_met = status.bit_last;
         sibe_pkg::COND_RSP_FREE:  cond_met = status.rsp_free;
         default:                  cond_met = 1'b0;
      endcase
   end

   // next step: jump, hold or fall through
   always_comb begin
      jump = cond_met ^ word.invert;
      if (jump) begin
         upc_in = word.target;
      end else if (word.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = sibe_pkg::step_type'(4'(upc_ff) + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= sibe_pkg::ST_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- hw/rtl/sibe_dpath.sv -----
module sibe_dpath #(
   parameter int STACK_BYTES = sibe_pkg::STACK_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sibe_pkg::act_type             act,
   output sibe_pkg::status_type          status,
   input  logic [sibe_pkg::ADDR_W-1:0]   stack_base,
   input  logic [sibe_pkg::SPAN_W-1:0]   stack_span,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [sibe_pkg::ADDR_W-1:0]   req_address,
   input  logic [sibe_pkg::ADDR_W-1:0]   req_source_address,
   input  logic [sibe_pkg::LEN_W-1:0]    req_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_uninitialized,
   output logic                          rsp_outside_region
);

   localparam int          MAP_BYTES  = (STACK_BYTES + 7) / 8;
   localparam int          MAP_W      = $clog2(MAP_BYTES);
   localparam int          POS_W      = sibe_pkg::POS_W;
   localparam int          AW         = sibe_pkg::ADDR_W;
   localparam logic [31:0] STORE_BITS = 32'(STACK_BYTES);
   localparam logic [31:0] STORE_LAST = 32'(MAP_BYTES - 1);

   // request registers
   sibe_pkg::op_type           op_ff, op_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [AW-1:0]              src_ff, src_in;
   logic [sibe_pkg::LEN_W-1:0] len_ff, len_in;
   // run registers
   logic [AW-1:0]              dst_off_ff, dst_off_in;
   logic [AW-1:0]              src_off_ff, src_off_in;
   logic                       outside_ff, outside_in;
   logic                       src_out_ff, src_out_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [POS_W-1:0]           spos_ff, spos_in;
   logic [POS_W-1:0]           lim_ff, lim_in;
   logic                       undef_ff, undef_in;
   logic                       sbit_ff, sbit_in;
   logic [MAP_W-1:0]           sweep_ff, sweep_in;
   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_uninit_ff, rsp_uninit_in;
   logic                       rsp_outside_ff, rsp_outside_in;

   // store port
   logic                       ram_we;
   logic [MAP_W-1:0]           ram_waddr;
   logic [7:0]                 ram_wdata;
   logic [MAP_W-1:0]           ram_raddr;
   logic [7:0]                 ram_rdata;

   // helpers
   logic                       req_fire;
   logic                       rsp_free;
   logic [POS_W-1:0]           len_eff;
   logic [POS_W-1:0]           run_end;
   logic [31:0]                dst_byte32;
   logic [31:0]                src_byte32;
   logic [MAP_W-1:0]           dst_addr;
   logic [MAP_W-1:0]           src_addr;
   logic [POS_W:0]             next_byte_pos;
   logic [POS_W:0]             next_bit_pos;
   logic [7:0]                 mask_lo;
   logic [7:0]                 mask_hi;
   logic [7:0]                 run_mask;
   logic [7:0]                 bit_mask;
   logic                       src_in_store;

   sibe_ram #(
      .WIDTH (8),
      .DEPTH (MAP_BYTES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // handshake
   assign req_stall = reset | (act != sibe_pkg::ACT_TAKE);
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // run geometry
   assign len_eff    = (len_ff == '0) ? POS_W'(1) : len_ff;
   assign run_end    = {1'b0, dst_off_ff[sibe_pkg::SPAN_W-1:0]} + len_eff;
   assign dst_byte32 = 32'(pos_ff[POS_W-1:3]);
   assign src_byte32 = 32'(spos_ff[POS_W-1:3]);
   assign dst_addr   = dst_byte32[MAP_W-1:0];
   assign src_addr   = src_byte32[MAP_W-1:0];
   assign next_byte_pos = {1'b0, pos_ff[POS_W-1:3], 3'b000} + (POS_W+1)'(8);
   assign next_bit_pos  = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign src_in_store  = 32'(spos_ff) < STORE_BITS;

   // bits of the current byte that lie in the run
   assign mask_lo  = sibe_pkg::BYTE_ONES << pos_ff[2:0];
   assign mask_hi  = (lim_ff[POS_W-1:3] == pos_ff[POS_W-1:3])
                   ? ((8'h01 << lim_ff[2:0]) - 8'h01) : sibe_pkg::BYTE_ONES;
   assign run_mask = mask_lo & mask_hi;
   assign bit_mask = 8'h01 << pos_ff[2:0];

   // status to the sequencer
   always_comb begin
      status.clr_last  = 32'(sweep_ff) == STORE_LAST;
      status.req_fire  = req_fire;
      status.empty     = outside_ff | (pos_ff >= lim_ff);
      status.copy_bits = (op_ff == sibe_pkg::OP_COPY) & ~src_out_ff;
      status.byte_last = next_byte_pos >= {1'b0, lim_ff};
      status.bit_last  = next_bit_pos >= {1'b0, lim_ff};
      status.rsp_free  = rsp_free;
   end

   // datapath actions
   always_comb begin
      op_in      = op_ff;
      addr_in    = addr_ff;
      src_in     = src_ff;
      len_in     = len_ff;
      dst_off_in = dst_off_ff;
      src_off_in = src_off_ff;
      outside_in = outside_ff;
      src_out_in = src_out_ff;
      pos_in     = pos_ff;
      spos_in    = spos_ff;
      lim_in     = lim_ff;
      undef_in   = undef_ff;
      sbit_in    = sbit_ff;
      sweep_in   = sweep_ff;
      ram_we     = 1'b0;
      ram_waddr  = dst_addr;
      ram_wdata  = ram_rdata;
      ram_raddr  = dst_addr;

      case (act)
         sibe_pkg::ACT_CLR_STORE: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + MAP_W'(1);
         end
         sibe_pkg::ACT_TAKE: begin
            if (req_fire) begin
               op_in   = sibe_pkg::op_type'(req_op);
               addr_in = req_address;
               src_in  = req_source_address;
               len_in  = req_length;
            end
         end
         sibe_pkg::ACT_OFFSETS: begin
            dst_off_in = addr_ff - stack_base;
            src_off_in = src_ff - stack_base;
         end
         sibe_pkg::ACT_BOUNDS: begin
            outside_in = dst_off_ff > 32'(stack_span);
            src_out_in = src_off_ff > 32'(stack_span);
            pos_in     = {1'b0, dst_off_ff[sibe_pkg::SPAN_W-1:0]};
            spos_in    = {1'b0, src_off_ff[sibe_pkg::SPAN_W-1:0]};
            // bits past the store are dropped
            lim_in     = (32'(run_end) > STORE_BITS) ? STORE_BITS[POS_W-1:0] : run_end;
            undef_in   = 1'b0;
         end
         sibe_pkg::ACT_RD_DST: begin
            ram_raddr = dst_addr;
         end
         sibe_pkg::ACT_BYTE_OP: begin
            case (op_ff)
               sibe_pkg::OP_CHECK: begin
                  undef_in = undef_ff | (|(~ram_rdata & run_mask));
               end
               sibe_pkg::OP_UNMARK: begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata & ~run_mask;
               end
               default: begin
                  // mark, and copy from a source outside the region
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata | run_mask;
               end
            endcase
            pos_in = next_byte_pos[POS_W-1:0];
         end
         sibe_pkg::ACT_RD_SRC: begin
            ram_raddr = src_addr;
         end
         sibe_pkg::ACT_GRAB: begin
            // source byte arrives now; fetch destination byte next
            sbit_in   = src_in_store & ram_rdata[spos_ff[2:0]];
            ram_raddr = dst_addr;
         end
         sibe_pkg::ACT_PUT: begin
            ram_we    = 1'b1;
            ram_wdata = sbit_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
            pos_in    = next_bit_pos[POS_W-1:0];
            spos_in   = spos_ff + POS_W'(1);
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_uninit_in  = rsp_uninit_ff;
      rsp_outside_in = rsp_outside_ff;
      if ((act == sibe_pkg::ACT_RESPOND) && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_uninit_in  = undef_ff;
         rsp_outside_in = outside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      src_ff         <= src_in;
      len_ff         <= len_in;
      dst_off_ff     <= dst_off_in;
      src_off_ff     <= src_off_in;
      outside_ff     <= outside_in;
      src_out_ff     <= src_out_in;
      pos_ff         <= pos_in;
      spos_ff        <= spos_in;
      lim_ff         <= lim_in;
      undef_ff       <= undef_in;
      sbit_ff        <= sbit_in;
      rsp_uninit_ff  <= rsp_uninit_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_uninitialized  = rsp_uninit_ff;
   assign rsp_outside_region = rsp_outside_ff;

   // loops never touch a bit at or past the end of the run
   a_in_run: assert property (@(posedge clock) disable iff (reset)
      (act == sibe_pkg::ACT_BYTE_OP || act == sibe_pkg::ACT_PUT) |-> (pos_ff < lim_ff))
      else $error("run step beyond run end");

   // a result only appears from the respond step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(act) == sibe_pkg::ACT_RESPOND))
      else $error("result raised outside respond step");

   // an address outside the region never reports an unmarked byte
   a_out_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_outside_ff && rsp_uninit_ff))
      else $error("outside result flagged uninitialized");

   // writes stay inside the store
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) <= STORE_LAST))
      else $error("store write out of range");

endmodule

// ----- sim/shadow_init_bitmap_engine_tb.sv -----
`timescale 1ns / 1ps

module shadow_init_bitmap_engine_tb;

   localparam int MAP_BITS        = sibe_pkg::STACK_BYTES_DEF;
   localparam int WATCHDOG_CYCLES = 60000;
   localparam int DRAIN_CYCLES    = 16;
   // indexes past the register list; writes there must do nothing
   localparam logic [sibe_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sibe_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef logic [sibe_pkg::LEN_W-1:0] len_type;

   typedef struct {
      logic uninitialized;
      logic outside_region;
   } shadow_outcome_type;

   // Shadow copy of the bitmap and registers, plus the outcomes still owed
   class shadow_map_scoreboard;
      bit                          shadow_bits [MAP_BITS];
      logic [sibe_pkg::ADDR_W-1:0] base;
      logic [sibe_pkg::SPAN_W-1:0] span;
      shadow_outcome_type          awaited [$];
      int                          errors;

      function new();
         base   = '0;
         span   = sibe_pkg::SPAN_RESET;
         errors = 0;
         foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
      endfunction

      // bits past the store read as zero and swallow writes
      function bit read_bit(int unsigned pos);
         return (pos < MAP_BITS) ? shadow_bits[pos] : 1'b0;
      endfunction

      function void write_bit(int unsigned pos, bit value);
         if (pos < MAP_BITS) shadow_bits[pos] = value;
      endfunction

      function void set_register(logic [sibe_pkg::CSR_IDX_W-1:0] idx,
                                 logic [sibe_pkg::CSR_DATA_W-1:0] data);
         if (idx == sibe_pkg::CSR_STACK_BASE) base = data;
         else if (idx == sibe_pkg::CSR_STACK_SPAN) span = data[sibe_pkg::SPAN_W-1:0];
      endfunction

      function void note_request(sibe_pkg::op_type op, logic [sibe_pkg::ADDR_W-1:0] dst,
                                 logic [sibe_pkg::ADDR_W-1:0] src, len_type len);
         shadow_outcome_type          res;
         logic [sibe_pkg::ADDR_W-1:0] dst_off;
         logic [sibe_pkg::ADDR_W-1:0] src_off;
         int unsigned                 run;
         res.uninitialized  = 1'b0;
         res.outside_region = 1'b0;
         run     = (len == 0) ? 1 : len;
         dst_off = dst - base;
         src_off = src - base;
         if (dst_off > span) begin
            res.outside_region = 1'b1;
         end else begin
            case (op)
               sibe_pkg::OP_CHECK: begin
                  for (int unsigned i = 0; i < run; i++)
                     if (dst_off + i < MAP_BITS && !read_bit(dst_off + i))
                        res.uninitialized = 1'b1;
               end
               sibe_pkg::OP_MARK: begin
                  for (int unsigned i = 0; i < run; i++) write_bit(dst_off + i, 1'b1);
               end
               sibe_pkg::OP_UNMARK: begin
                  for (int unsigned i = 0; i < run; i++) write_bit(dst_off + i, 1'b0);
               end
               default: begin
                  // source outside the region: destination becomes defined
                  if (src_off > span) begin
                     for (int unsigned i = 0; i < run; i++) write_bit(dst_off + i, 1'b1);
                  end else begin
                     // ascending, one bit at a time, so overlaps see fresh writes
                     for (int unsigned i = 0; i < run; i++)
                        write_bit(dst_off + i, read_bit(src_off + i));
                  end
               end
            endcase
         end
         awaited.push_back(res);
      endfunction

      function void check_result(logic uninitialized, logic outside_region);
         shadow_outcome_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, uninitialized %0b outside_region %0b",
                     $time, uninitialized, outside_region);
            return;
         end
         want = awaited.pop_front();
         if (uninitialized !== want.uninitialized) begin
            errors++;
            $display("%0t: uninitialized mismatch, expected %0b, got %0b",
                     $time, want.uninitialized, uninitialized);
         end
         if (outside_region !== want.outside_region) begin
            errors++;
            $display("%0t: outside_region mismatch, expected %0b, got %0b",
                     $time, want.outside_region, outside_region);
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   sibe_pkg::op_type                req_op;
   logic [sibe_pkg::ADDR_W-1:0]     req_address;
   logic [sibe_pkg::ADDR_W-1:0]     req_source_address;
   len_type                         req_length;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_uninitialized;
   logic                            rsp_outside_region;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [sibe_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sibe_pkg::CSR_DATA_W-1:0] csr_data;

   shadow_map_scoreboard   sb;
   int                     idle_cycles = 0;

   shadow_init_bitmap_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_source_address (req_source_address),
      .req_length         (req_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_uninitialized  (rsp_uninitialized),
      .rsp_outside_region (rsp_outside_region),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Handshake monitor and watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (rsp_valid && !rsp_stall)
         sb.check_result(rsp_uninitialized, rsp_outside_region);
      if (req_valid && !req_stall)
         sb.note_request(req_op, req_address, req_source_address, req_length);
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side back-pressure: mostly short stalls, some long, some long clear runs
   initial begin : rsp_pacing
      int unsigned r;
      int unsigned clear_len;
      int unsigned hold_len;
      rsp_stall = 1'b0;
      forever begin
         r         = $urandom_range(0, 99);
         clear_len = (r < 10) ? $urandom_range(100, 400) : $urandom_range(1, 30);
         repeat (clear_len) @(negedge clock);
         r        = $urandom_range(0, 99);
         hold_len = (r < 70) ? $urandom_range(1, 2) :
                    (r < 95) ? $urandom_range(3, 8) : $urandom_range(20, 100);
         rsp_stall = 1'b1;
         repeat (hold_len) @(negedge clock);
         rsp_stall = 1'b0;
      end
   end

   // Called at a falling edge; returns at a falling edge
   task automatic send_request(sibe_pkg::op_type op, logic [sibe_pkg::ADDR_W-1:0] dst,
                               logic [sibe_pkg::ADDR_W-1:0] src, len_type len, int gap);
      req_valid          = 1'b1;
      req_op             = op;
      req_address        = dst;
      req_source_address = src;
      req_length         = len;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_register(logic [sibe_pkg::CSR_IDX_W-1:0] idx,
                                 logic [sibe_pkg::CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sender holds off until every owed result has been taken
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic set_region(logic [sibe_pkg::CSR_DATA_W-1:0] base,
                             logic [sibe_pkg::CSR_DATA_W-1:0] span);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_register(sibe_pkg::CSR_STACK_BASE, base);
      write_register(sibe_pkg::CSR_STACK_SPAN, span);
   endtask

   // Mostly near the start of the region, some anywhere in it, some just past, some wild
   function automatic logic [sibe_pkg::ADDR_W-1:0] pick_address();
      int unsigned r;
      int unsigned near_top;
      r        = $urandom_range(0, 99);
      near_top = (sb.span < 255) ? sb.span : 255;
      if (r < 70) return sb.base + $urandom_range(0, near_top);
      if (r < 85) return sb.base + $urandom_range(0, sb.span);
      if (r < 93) return sb.base + sb.span + $urandom_range(1, 64);
      return $urandom();
   endfunction

   // Short runs dominate; full-store runs are rare since copies walk bit by bit
   function automatic len_type pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return len_type'($urandom_range(0, 24));
      if (r < 97) return len_type'($urandom_range(25, 300));
      return len_type'($urandom_range(301, 4096));
   endfunction

   function automatic sibe_pkg::op_type pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return sibe_pkg::OP_CHECK;
      if (r < 65) return sibe_pkg::OP_MARK;
      if (r < 80) return sibe_pkg::OP_UNMARK;
      return sibe_pkg::OP_COPY;
   endfunction

   function automatic int pick_gap(int k);
      int unsigned r;
      r = $urandom_range(0, 99);
      if ((k % 64) < 12 || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random items; a quarter reuse the previous run so marks get checked and copied
   task automatic run_random(int count);
      sibe_pkg::op_type            op;
      logic [sibe_pkg::ADDR_W-1:0] dst;
      logic [sibe_pkg::ADDR_W-1:0] src;
      len_type                     len;
      dst = sb.base;
      len = 1;
      for (int k = 0; k < count; k++) begin
         op = pick_op();
         if (k == 0 || $urandom_range(0, 3) != 0) begin
            dst = pick_address();
            len = pick_length();
         end
         src = pick_address();
         if (k == count / 2) wait_for_results();
         send_request(op, dst, src, len, pick_gap(k));
      end
   endtask

   // Directed items under the reset region (base 0, span 4095)
   task automatic run_directed();
      send_request(sibe_pkg::OP_CHECK,  0, 0, 0, 0);       // zero length, fresh store
      send_request(sibe_pkg::OP_MARK,   0, 0, 0, 1);       // zero length marks one bit
      send_request(sibe_pkg::OP_CHECK,  0, 0, 1, 0);
      send_request(sibe_pkg::OP_CHECK,  0, 0, 2, 0);
      send_request(sibe_pkg::OP_MARK,   16, 0, 64, 2);
      send_request(sibe_pkg::OP_CHECK,  16, 0, 64, 0);
      send_request(sibe_pkg::OP_CHECK,  15, 0, 64, 0);
      send_request(sibe_pkg::OP_UNMARK, 40, 0, 8, 0);
      send_request(sibe_pkg::OP_CHECK,  16, 0, 64, 3);
      send_request(sibe_pkg::OP_COPY,   100, 16, 64, 0);
      send_request(sibe_pkg::OP_CHECK,  100, 0, 24, 0);
      send_request(sibe_pkg::OP_COPY,   20, 16, 40, 0);    // overlap, source below destination
      send_request(sibe_pkg::OP_COPY,   16, 20, 40, 0);    // overlap, source above destination
      send_request(sibe_pkg::OP_COPY,   3000, 32'hFFFF_FFFF, 100, 0);  // source outside region
      send_request(sibe_pkg::OP_CHECK,  3000, 0, 100, 0);
      send_request(sibe_pkg::OP_MARK,   4090, 0, 20, 0);   // run past the end of the store
      send_request(sibe_pkg::OP_CHECK,  4088, 0, 100, 0);
      send_request(sibe_pkg::OP_CHECK,  4090, 0, 100, 0);
      send_request(sibe_pkg::OP_COPY,   200, 4094, 8, 0);  // source reads past the store
      send_request(sibe_pkg::OP_CHECK,  4096, 0, 1, 0);    // just outside the region
      send_request(sibe_pkg::OP_MARK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4096, 0);
      send_request(sibe_pkg::OP_MARK,   0, 0, 4096, 0);
      send_request(sibe_pkg::OP_CHECK,  0, 0, 4096, 0);
      send_request(sibe_pkg::OP_UNMARK, 4095, 0, 4096, 0);
      send_request(sibe_pkg::OP_COPY,   0, 2048, 4096, 0);
   endtask

   initial begin : stimulus
      sb                 = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = sibe_pkg::OP_CHECK;
      req_address        = '0;
      req_source_address = '0;
      req_length         = '0;
      csr_valid          = 1'b0;
      csr_index          = sibe_pkg::CSR_STACK_BASE;
      csr_data           = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      run_directed();

      // plain region at zero
      set_region(32'h0000_0000, 32'd4095);
      run_random(160);
      // region wrapping through address zero
      set_region(32'hFFFF_FF80, 32'd4095);
      run_random(160);
      // single tracked byte
      set_region($urandom(), 32'd0);
      run_random(150);
      // base at the top of the address space, small span
      set_region(32'hFFFF_FFFF, $urandom_range(16, 300));
      run_random(160);
      // spare indexes ignored, span keeps only its low bits
      set_region($urandom(), $urandom_range(64, 4095));
      write_register(CSR_SPARE_2, $urandom());
      write_register(CSR_SPARE_3, $urandom());
      write_register(sibe_pkg::CSR_STACK_SPAN,
                     {20'($urandom_range(1, 20'hFFFFF)), 12'($urandom_range(32, 4095))});
      run_random(160);
      set_region(32'h8000_0000, 32'd4095);
      run_random(160);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/sibe_pkg.sv
hw/rtl/sibe_ram.sv
hw/rtl/sibe_seq.sv
hw/rtl/sibe_dpath.sv
hw/rtl/shadow_init_bitmap_engine.sv
sim/shadow_init_bitmap_engine_tb.sv
